>>> rtl/oks_pkg.sv
// Package: shared constants and types for the ordered key set.
`default_nettype none
package oks_pkg;
  localparam int KEY_BITS   = 16;
  localparam int LEAF_WORDS = 1024;
  localparam int LEAF_AW    = 10;
  localparam int MID_WORDS  = 16;
  localparam int MID_AW     = 4;
  localparam int CNT_W      = 17;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_ERASE  = 2'd1;
  localparam logic [1:0] CMD_QUERY  = 2'd2;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef logic [63:0] word_t;

  // index of lowest set bit of a 64-bit word (zero if none)
  function automatic logic [5:0] low_bit(input word_t v);
    logic [5:0] n;
    n = 6'd0;
    for (int i = 63; i >= 0; i--) begin
      if (v[i]) n = 6'(i);
    end
    return n;
  endfunction

  // index of lowest set bit of a 16-bit word
  function automatic logic [3:0] low_bit16(input logic [15:0] v);
    logic [3:0] n;
    n = 4'd0;
    for (int i = 15; i >= 0; i--) begin
      if (v[i]) n = 4'(i);
    end
    return n;
  endfunction
endpackage
`default_nettype wire

>>> rtl/oks_ram.sv
// Generic single-port-write, one-read synchronous RAM with registered read.
`default_nettype none
module oks_ram #(
  parameter int AW = 10,
  parameter int DW = 64
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);
  logic [DW-1:0] mem [0:(1<<AW)-1];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

>>> rtl/ordered_key_set_successor.sv
// Top level: ordered key set with insert, erase and lower-bound query.
//
// Input channel in_valid/in_ready carries in_command and in_key; result
// channel out_valid/out_ready carries out_found, out_result_key and
// out_key_count, one result transaction per input transaction.
// The leaf bitmap (1024 x 64) lives in a synchronous RAM; the middle level
// (16 x 64) and top level (16 bits) live in flip-flops.
// Flow: after the accepting edge, insert, erase and a query answered from
// the key's own leaf word pass through LEAF and DONE; a query that needs a
// second leaf read passes LEAF, RD1, RD2 and DONE. out_valid rises when
// DONE loads the output register. A new transaction is taken only once
// the previous one has left DONE.
// After reset a clearing pass writes zero to all 1024 leaf words, one per
// cycle; in_ready stays low until the pass is done.
// One transaction is worked on at a time. The result sits in an output
// register; a new input is taken while a finished result waits, and the
// block holds in the final step until the output register is free.
`default_nettype none
module ordered_key_set_successor (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_command,
  input  wire logic [15:0] in_key,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_found,
  output logic [15:0]      out_result_key,
  output logic [16:0]      out_key_count
);
  import oks_pkg::*;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_RD1   = 3'd2;
  localparam logic [2:0] ST_LEAF  = 3'd3;
  localparam logic [2:0] ST_RD2   = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  logic [2:0]         state_r, state_nxt;
  logic [LEAF_AW-1:0] clr_r;
  logic [1:0]         cmd_r;
  logic [15:0]        key_r;
  word_t              mid_r [0:MID_WORDS-1];
  logic [15:0]        top_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               ov_r, of_r;
  logic [15:0]        ok_r;
  logic               res_f_r;
  logic [15:0]        res_k_r;
  logic [LEAF_AW-1:0] w2_r;

  logic               we;
  logic [LEAF_AW-1:0] waddr, raddr;
  word_t              wdata, rdata;

  oks_ram #(.AW(LEAF_AW), .DW(64)) u_leaf (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rdata)
  );

  // key split
  logic [LEAF_AW-1:0] w;
  logic [MID_AW-1:0]  mw;
  logic [5:0]         kb;
  assign w  = key_r[15:6];
  assign mw = key_r[15:12];
  assign kb = key_r[5:0];

  word_t bitm, leaf_hit, mid_above, mid_cur;
  logic [15:0] top_above;
  logic [MID_AW-1:0] mw2;
  assign bitm      = word_t'(1) << kb;
  assign leaf_hit  = rdata & ~((bitm) - word_t'(1));
  assign mid_cur   = mid_r[mw];
  assign mid_above = mid_cur & ((~word_t'(0) << w[5:0]) << 1);
  assign top_above = top_r & ((16'hffff << mw) << 1);
  assign mw2       = low_bit16(top_above);

  assign in_ready = (state_r == ST_IDLE);
  assign raddr    = (state_r == ST_IDLE) ? in_key[15:6] : w2_r;

  // leaf update on insert/erase
  word_t newleaf;
  logic  chg;
  always_comb begin
    newleaf = rdata;
    chg     = 1'b0;
    if (cmd_r == CMD_INSERT && (rdata & bitm) == '0) begin
      newleaf = rdata | bitm; chg = 1'b1;
    end else if (cmd_r == CMD_ERASE && (rdata & bitm) != '0) begin
      newleaf = rdata & ~bitm; chg = 1'b1;
    end
  end

  always_comb begin
    we    = 1'b0;
    waddr = w;
    wdata = newleaf;
    if (state_r == ST_CLEAR) begin
      we = 1'b1; waddr = clr_r; wdata = '0;
    end else if (state_r == ST_LEAF && chg) begin
      we = 1'b1;
    end
  end

  logic out_free;
  assign out_free = !ov_r || out_ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: if (clr_r == LEAF_AW'(LEAF_WORDS - 1)) state_nxt = ST_IDLE;
      ST_IDLE:  if (in_valid) state_nxt = ST_LEAF;
      ST_LEAF: begin
        if (cmd_r == CMD_QUERY && leaf_hit == '0 &&
            (mid_above != '0 || top_above != '0)) state_nxt = ST_RD1;
        else state_nxt = ST_DONE;
      end
      ST_RD1:   state_nxt = ST_RD2;
      ST_RD2:   state_nxt = ST_DONE;
      ST_DONE:  if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r   <= '0;
      top_r   <= '0;
      cnt_r   <= '0;
      ov_r    <= 1'b0;
      for (int i = 0; i < MID_WORDS; i++) mid_r[i] <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) clr_r <= clr_r + LEAF_AW'(1);
      // output register loads when free, empties on accept
      if (state_r == ST_DONE && out_free) ov_r <= 1'b1;
      else if (out_ready) ov_r <= 1'b0;
      // summary levels update together with the leaf write
      if (state_r == ST_LEAF && chg) begin
        if (cmd_r == CMD_INSERT) begin
          mid_r[mw][w[5:0]] <= 1'b1;
          top_r[mw]         <= 1'b1;
          cnt_r             <= cnt_r + CNT_W'(1);
        end else begin
          if (newleaf == '0) begin
            mid_r[mw][w[5:0]] <= 1'b0;
            if ((mid_cur & ~(word_t'(1) << w[5:0])) == '0) top_r[mw] <= 1'b0;
          end
          cnt_r <= cnt_r - CNT_W'(1);
        end
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_valid) begin
      cmd_r <= in_command; key_r <= in_key;
    end
    if (state_r == ST_LEAF) begin
      if (cmd_r == CMD_QUERY && leaf_hit != '0) begin
        res_f_r <= 1'b1; res_k_r <= {w, low_bit(leaf_hit)};
      end else begin
        res_f_r <= 1'b0; res_k_r <= '0;
      end
      if (cmd_r == CMD_QUERY && leaf_hit == '0) begin
        if (mid_above != '0) begin
          w2_r <= {mw, low_bit(mid_above)};
        end else begin
          w2_r <= {mw2, low_bit(mid_r[mw2])};
        end
      end
    end
    if (state_r == ST_RD2) begin
      res_f_r <= 1'b1; res_k_r <= {w2_r, low_bit(rdata)};
    end
    if (state_r == ST_DONE && out_free) begin
      of_r <= res_f_r; ok_r <= res_k_r; out_key_count <= cnt_r;
    end
  end

  assign out_valid      = ov_r;
  assign out_found      = of_r;
  assign out_result_key = ok_r;
endmodule
`default_nettype wire

>>> rtl/oks_checker.sv
// Checker: port-level assertions for the ordered key set, bound to the top.
`default_nettype none
module oks_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        out_found,
  input wire logic [15:0] out_result_key,
  input wire logic [16:0] out_key_count
);
  a_nf_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_result_key == 16'd0) else $error("key not zero");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result_key))
    else $error("result dropped");
  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_key_count <= 17'h10000) else $error("count range");
  a_no_accept_after: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready) else $error("overlapping transactions");
endmodule

bind ordered_key_set_successor oks_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_found(out_found),
  .out_result_key(out_result_key), .out_key_count(out_key_count)
);
`default_nettype wire
